/* rtl/core/sdspi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, codes and command tables for the SD card SPI-mode init/read core.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned WAKE_BYTES  = 10;

    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INIT_FAIL = 2'd1;
    localparam logic [1:0] ST_READ_REJ  = 2'd2;

    localparam logic [1:0] CFG_IDLE_ATTEMPTS = 2'd0;
    localparam logic [1:0] CFG_OP_ATTEMPTS   = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT    = 2'd2;

    localparam logic [7:0] FILL_BYTE  = 8'hff;
    localparam logic [7:0] DATA_TOKEN = 8'hfe;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY   = 8'h00;

    localparam logic [31:0] ARG_IF_COND = 32'h0000_01aa;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WAKE,
        MODE_CMD,
        MODE_TOKEN,
        MODE_DATA,
        MODE_CRC
    } mode_t;

    typedef enum logic [2:0] {
        OP_CMD0,
        OP_CMD8,
        OP_CMD55,
        OP_ACMD41,
        OP_CMD58,
        OP_CMD1,
        OP_CMD16,
        OP_CMD17
    } op_t;

    typedef enum logic [1:0] {
        SUB_SEND,
        SUB_POLL,
        SUB_READ4,
        SUB_DESEL
    } sub_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       card_selected;
        logic       fast_clock;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       done_res;
        logic [1:0] status;
        logic       high_capacity;
    } result_t;

    function automatic logic [7:0] cmd_code(input op_t op);
        logic [7:0] code;
        case (op)
            OP_CMD0:   code = 8'h40;
            OP_CMD8:   code = 8'h48;
            OP_CMD55:  code = 8'h77;
            OP_ACMD41: code = 8'h69;
            OP_CMD58:  code = 8'h7a;
            OP_CMD1:   code = 8'h41;
            OP_CMD16:  code = 8'h50;
            OP_CMD17:  code = 8'h51;
            default:   code = 8'h40;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] cmd_crc(input op_t op);
        logic [7:0] crc;
        case (op)
            OP_CMD0: crc = 8'h95;
            OP_CMD8: crc = 8'h87;
            default: crc = FILL_BYTE;
        endcase
        return crc;
    endfunction

    function automatic logic [31:0] cmd_arg(input op_t op);
        logic [31:0] arg;
        case (op)
            OP_CMD8:   arg = ARG_IF_COND;
            OP_ACMD41: arg = ARG_HCS;
            OP_CMD1:   arg = ARG_HCS;
            OP_CMD16:  arg = 32'(BLOCK_BYTES);
            default:   arg = 32'h0;
        endcase
        return arg;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sd_spi_init_and_block_read_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_init_and_block_read_core
// Host-side SD/MMC SPI-mode sequencer: card init and single block read,
// at most one SPI byte exchange per input transaction.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid/in_ready, action/sector/rx  | sink
//  out     | out_valid/out_ready, tx_*/data_*/... | source
//  cfg     | cfg_we, cfg_index, cfg_data          | sink
//
//  One input transaction per clock while the output is not stalled; each result
//  is registered and ready in the cycle after acceptance.
//  Input is taken while the result register is empty or being drained.
//  rst_n resets the sequencer to idle and all registers but res_reg to defaults.
//  A stalled output holds the result and stalls the input side.
// ----------------------------------------------------------------------------
module sd_spi_init_and_block_read_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] sector,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             card_selected,
    output logic             fast_clock,
    output logic             data_valid,
    output logic [7:0]       data_byte,
    output logic             data_last,
    output logic             done_res,
    output logic [1:0]       status,
    output logic             high_capacity
);

    logic [7:0]  idle_attempts_reg;
    logic [15:0] op_attempts_reg;
    logic [15:0] poll_limit_reg;

    sdspi_pkg::mode_t mode_reg, mode_next;
    sdspi_pkg::op_t   op_reg, op_next;
    sdspi_pkg::sub_t  sub_reg, sub_next;
    logic [9:0]  byte_cnt_reg, byte_cnt_next;
    logic [15:0] attempt_reg, attempt_next;
    logic [15:0] poll_cnt_reg, poll_cnt_next;
    logic [31:0] word_reg, word_next;
    logic [7:0]  last_resp_reg, last_resp_next;
    logic        sdhc_reg, sdhc_next;
    logic        fast_reg, fast_next;

    sdspi_pkg::result_t res_reg, res_next;
    logic               out_valid_reg;

    logic [9:0]  byte_inc;
    logic [15:0] poll_inc;
    logic [31:0] word_shifted;
    logic        go_cmd;
    sdspi_pkg::op_t go_op;
    logic        go_desel;
    logic        go_fin;
    logic [1:0]  go_status;
    logic        accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign byte_inc     = byte_cnt_reg + 10'd1;
    assign poll_inc     = poll_cnt_reg + 16'd1;
    assign word_shifted = {word_reg[23:0], rx_byte};

    always_comb
    begin
        mode_next      = mode_reg;
        op_next        = op_reg;
        sub_next       = sub_reg;
        byte_cnt_next  = byte_cnt_reg;
        attempt_next   = attempt_reg;
        poll_cnt_next  = poll_cnt_reg;
        word_next      = word_reg;
        last_resp_next = last_resp_reg;
        sdhc_next      = sdhc_reg;
        fast_next      = fast_reg;
        res_next       = '0;
        go_cmd         = 1'b0;
        go_op          = sdspi_pkg::OP_CMD0;
        go_desel       = 1'b0;
        go_fin         = 1'b0;
        go_status      = sdspi_pkg::ST_OK;

        case (action)
            sdspi_pkg::ACT_INIT:
            begin
                fast_next              = 1'b0;
                attempt_next           = {8'h00, idle_attempts_reg};
                sdhc_next              = 1'b0;
                mode_next              = sdspi_pkg::MODE_WAKE;
                byte_cnt_next          = '0;
                res_next.tx_valid      = 1'b1;
                res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                res_next.card_selected = 1'b0;
            end
            sdspi_pkg::ACT_READ:
            begin
                mode_next              = sdspi_pkg::MODE_CMD;
                op_next                = sdspi_pkg::OP_CMD17;
                sub_next               = sdspi_pkg::SUB_SEND;
                byte_cnt_next          = '0;
                poll_cnt_next          = '0;
                word_next              = sdhc_reg ? sector : {sector[22:0], 9'h000};
                res_next.tx_valid      = 1'b1;
                res_next.tx_byte       = sdspi_pkg::cmd_code(sdspi_pkg::OP_CMD17);
                res_next.card_selected = 1'b1;
            end
            sdspi_pkg::ACT_BYTE:
            begin
                case (mode_reg)
                    sdspi_pkg::MODE_IDLE:
                    begin
                        mode_next = sdspi_pkg::MODE_IDLE;
                    end
                    sdspi_pkg::MODE_WAKE:
                    begin
                        byte_cnt_next = byte_inc;
                        if (byte_inc < 10'(sdspi_pkg::WAKE_BYTES))
                        begin
                            res_next.tx_valid = 1'b1;
                            res_next.tx_byte  = sdspi_pkg::FILL_BYTE;
                        end
                        else
                        begin
                            go_cmd = 1'b1;
                            go_op  = sdspi_pkg::OP_CMD0;
                        end
                    end
                    sdspi_pkg::MODE_TOKEN:
                    begin
                        if (rx_byte == sdspi_pkg::DATA_TOKEN)
                        begin
                            mode_next     = sdspi_pkg::MODE_DATA;
                            byte_cnt_next = '0;
                        end
                        res_next.tx_valid      = 1'b1;
                        res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                        res_next.card_selected = 1'b1;
                    end
                    sdspi_pkg::MODE_DATA:
                    begin
                        res_next.data_valid    = 1'b1;
                        res_next.data_byte     = rx_byte;
                        byte_cnt_next          = byte_inc;
                        if (byte_inc >= 10'(sdspi_pkg::BLOCK_BYTES))
                        begin
                            res_next.data_last = 1'b1;
                            mode_next          = sdspi_pkg::MODE_CRC;
                            byte_cnt_next      = '0;
                        end
                        res_next.tx_valid      = 1'b1;
                        res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                        res_next.card_selected = 1'b1;
                    end
                    sdspi_pkg::MODE_CRC:
                    begin
                        byte_cnt_next = byte_inc;
                        if (byte_inc < 10'd2)
                        begin
                            res_next.tx_valid      = 1'b1;
                            res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                            res_next.card_selected = 1'b1;
                        end
                        else
                        begin
                            mode_next = sdspi_pkg::MODE_CMD;
                            op_next   = sdspi_pkg::OP_CMD17;
                            go_desel  = 1'b1;
                        end
                    end
                    sdspi_pkg::MODE_CMD:
                    begin
                        case (sub_reg)
                            sdspi_pkg::SUB_SEND:
                            begin
                                byte_cnt_next          = byte_inc;
                                res_next.tx_valid      = 1'b1;
                                res_next.card_selected = 1'b1;
                                case (byte_inc)
                                    10'd1:   res_next.tx_byte = word_reg[31:24];
                                    10'd2:   res_next.tx_byte = word_reg[23:16];
                                    10'd3:   res_next.tx_byte = word_reg[15:8];
                                    10'd4:   res_next.tx_byte = word_reg[7:0];
                                    10'd5:   res_next.tx_byte = sdspi_pkg::cmd_crc(op_reg);
                                    default:
                                    begin
                                        sub_next         = sdspi_pkg::SUB_POLL;
                                        res_next.tx_byte = sdspi_pkg::FILL_BYTE;
                                    end
                                endcase
                            end
                            sdspi_pkg::SUB_POLL:
                            begin
                                poll_cnt_next = poll_inc;
                                if (!rx_byte[7] || (poll_inc >= poll_limit_reg))
                                begin
                                    last_resp_next = rx_byte;
                                    if (((op_reg == sdspi_pkg::OP_CMD8) &&
                                         (rx_byte == sdspi_pkg::R1_IDLE)) ||
                                        ((op_reg == sdspi_pkg::OP_CMD58) &&
                                         (rx_byte <= sdspi_pkg::R1_IDLE)))
                                    begin
                                        sub_next               = sdspi_pkg::SUB_READ4;
                                        byte_cnt_next          = '0;
                                        word_next              = '0;
                                        res_next.tx_valid      = 1'b1;
                                        res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                                        res_next.card_selected = 1'b1;
                                    end
                                    else if ((op_reg == sdspi_pkg::OP_CMD17) &&
                                             (rx_byte == sdspi_pkg::R1_READY))
                                    begin
                                        mode_next              = sdspi_pkg::MODE_TOKEN;
                                        res_next.tx_valid      = 1'b1;
                                        res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                                        res_next.card_selected = 1'b1;
                                    end
                                    else
                                    begin
                                        go_desel = 1'b1;
                                    end
                                end
                                else
                                begin
                                    res_next.tx_valid      = 1'b1;
                                    res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                                    res_next.card_selected = 1'b1;
                                end
                            end
                            sdspi_pkg::SUB_READ4:
                            begin
                                word_next     = word_shifted;
                                byte_cnt_next = byte_inc;
                                if (byte_inc < 10'd4)
                                begin
                                    res_next.tx_valid      = 1'b1;
                                    res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
                                    res_next.card_selected = 1'b1;
                                end
                                else
                                begin
                                    if ((op_reg == sdspi_pkg::OP_CMD58) && word_shifted[30])
                                    begin
                                        sdhc_next = 1'b1;
                                    end
                                    go_desel = 1'b1;
                                end
                            end
                            sdspi_pkg::SUB_DESEL:
                            begin
                                byte_cnt_next = byte_inc;
                                if (byte_inc < 10'd3)
                                begin
                                    res_next.tx_valid = 1'b1;
                                    res_next.tx_byte  = sdspi_pkg::FILL_BYTE;
                                end
                                else
                                begin
                                    case (op_reg)
                                        sdspi_pkg::OP_CMD0:
                                        begin
                                            if (last_resp_reg[7])
                                            begin
                                                go_fin    = 1'b1;
                                                go_status = sdspi_pkg::ST_INIT_FAIL;
                                            end
                                            else if (last_resp_reg != sdspi_pkg::R1_IDLE)
                                            begin
                                                if (attempt_reg <= 16'd1)
                                                begin
                                                    go_fin    = 1'b1;
                                                    go_status = sdspi_pkg::ST_INIT_FAIL;
                                                end
                                                else
                                                begin
                                                    attempt_next      = attempt_reg - 16'd1;
                                                    sdhc_next         = 1'b0;
                                                    mode_next         = sdspi_pkg::MODE_WAKE;
                                                    byte_cnt_next     = '0;
                                                    res_next.tx_valid = 1'b1;
                                                    res_next.tx_byte  = sdspi_pkg::FILL_BYTE;
                                                end
                                            end
                                            else
                                            begin
                                                go_cmd = 1'b1;
                                                go_op  = sdspi_pkg::OP_CMD8;
                                            end
                                        end
                                        sdspi_pkg::OP_CMD8:
                                        begin
                                            attempt_next = op_attempts_reg;
                                            go_cmd       = 1'b1;
                                            go_op        = sdspi_pkg::OP_CMD55;
                                        end
                                        sdspi_pkg::OP_CMD55:
                                        begin
                                            go_cmd = 1'b1;
                                            if (last_resp_reg != sdspi_pkg::R1_IDLE)
                                            begin
                                                attempt_next = op_attempts_reg;
                                                go_op        = sdspi_pkg::OP_CMD1;
                                            end
                                            else
                                            begin
                                                go_op = sdspi_pkg::OP_ACMD41;
                                            end
                                        end
                                        sdspi_pkg::OP_ACMD41:
                                        begin
                                            go_cmd = 1'b1;
                                            if ((last_resp_reg == sdspi_pkg::R1_IDLE) &&
                                                (attempt_reg > 16'd1))
                                            begin
                                                attempt_next = attempt_reg - 16'd1;
                                                go_op        = sdspi_pkg::OP_CMD55;
                                            end
                                            else if (last_resp_reg != sdspi_pkg::R1_READY)
                                            begin
                                                attempt_next = op_attempts_reg;
                                                go_op        = sdspi_pkg::OP_CMD1;
                                            end
                                            else
                                            begin
                                                go_op = sdspi_pkg::OP_CMD58;
                                            end
                                        end
                                        sdspi_pkg::OP_CMD58:
                                        begin
                                            attempt_next = op_attempts_reg;
                                            go_cmd       = 1'b1;
                                            go_op        = sdspi_pkg::OP_CMD1;
                                        end
                                        sdspi_pkg::OP_CMD1:
                                        begin
                                            if ((last_resp_reg != sdspi_pkg::R1_READY) &&
                                                (attempt_reg > 16'd1))
                                            begin
                                                attempt_next = attempt_reg - 16'd1;
                                                go_cmd       = 1'b1;
                                                go_op        = sdspi_pkg::OP_CMD1;
                                            end
                                            else if (last_resp_reg != sdspi_pkg::R1_READY)
                                            begin
                                                go_fin    = 1'b1;
                                                go_status = sdspi_pkg::ST_INIT_FAIL;
                                            end
                                            else
                                            begin
                                                go_cmd = 1'b1;
                                                go_op  = sdspi_pkg::OP_CMD16;
                                            end
                                        end
                                        sdspi_pkg::OP_CMD16:
                                        begin
                                            go_fin = 1'b1;
                                            if (last_resp_reg != sdspi_pkg::R1_READY)
                                            begin
                                                go_status = sdspi_pkg::ST_INIT_FAIL;
                                            end
                                            else
                                            begin
                                                fast_next = 1'b1;
                                                go_status = sdspi_pkg::ST_OK;
                                            end
                                        end
                                        default:
                                        begin
                                            go_fin    = 1'b1;
                                            go_status = (last_resp_reg != sdspi_pkg::R1_READY) ?
                                                        sdspi_pkg::ST_READ_REJ : sdspi_pkg::ST_OK;
                                        end
                                    endcase
                                end
                            end
                            default:
                            begin
                                mode_next = sdspi_pkg::MODE_IDLE;
                            end
                        endcase
                    end
                    default:
                    begin
                        mode_next = sdspi_pkg::MODE_IDLE;
                    end
                endcase
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        if (go_desel)
        begin
            sub_next               = sdspi_pkg::SUB_DESEL;
            byte_cnt_next          = '0;
            res_next.tx_valid      = 1'b1;
            res_next.tx_byte       = sdspi_pkg::FILL_BYTE;
            res_next.card_selected = 1'b0;
        end
        if (go_cmd)
        begin
            mode_next              = sdspi_pkg::MODE_CMD;
            op_next                = go_op;
            sub_next               = sdspi_pkg::SUB_SEND;
            byte_cnt_next          = '0;
            poll_cnt_next          = '0;
            word_next              = sdspi_pkg::cmd_arg(go_op);
            res_next.tx_valid      = 1'b1;
            res_next.tx_byte       = sdspi_pkg::cmd_code(go_op);
            res_next.card_selected = 1'b1;
        end
        if (go_fin)
        begin
            mode_next         = sdspi_pkg::MODE_IDLE;
            res_next.done_res = 1'b1;
            res_next.status   = go_status;
        end

        res_next.fast_clock    = fast_next;
        res_next.high_capacity = sdhc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_attempts_reg <= 8'd3;
            op_attempts_reg   <= 16'hffff;
            poll_limit_reg    <= 16'hffff;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdspi_pkg::CFG_IDLE_ATTEMPTS: idle_attempts_reg <= cfg_data[7:0];
                sdspi_pkg::CFG_OP_ATTEMPTS:   op_attempts_reg   <= cfg_data;
                sdspi_pkg::CFG_POLL_LIMIT:    poll_limit_reg    <= cfg_data;
                default:                      idle_attempts_reg <= idle_attempts_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= sdspi_pkg::MODE_IDLE;
            op_reg        <= sdspi_pkg::OP_CMD0;
            sub_reg       <= sdspi_pkg::SUB_SEND;
            byte_cnt_reg  <= '0;
            attempt_reg   <= '0;
            poll_cnt_reg  <= '0;
            word_reg      <= '0;
            last_resp_reg <= '0;
            sdhc_reg      <= 1'b0;
            fast_reg      <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            op_reg        <= op_next;
            sub_reg       <= sub_next;
            byte_cnt_reg  <= byte_cnt_next;
            attempt_reg   <= attempt_next;
            poll_cnt_reg  <= poll_cnt_next;
            word_reg      <= word_next;
            last_resp_reg <= last_resp_next;
            sdhc_reg      <= sdhc_next;
            fast_reg      <= fast_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_valid      = res_reg.tx_valid;
    assign tx_byte       = res_reg.tx_byte;
    assign card_selected = res_reg.card_selected;
    assign fast_clock    = res_reg.fast_clock;
    assign data_valid    = res_reg.data_valid;
    assign data_byte     = res_reg.data_byte;
    assign data_last     = res_reg.data_last;
    assign done_res      = res_reg.done_res;
    assign status        = res_reg.status;
    assign high_capacity = res_reg.high_capacity;

`ifndef SYNTHESIS
    a_data_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.data_valid) |-> (res_reg.tx_valid && res_reg.card_selected))
        else $error("data byte without a selected exchange");

    a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> (!res_reg.tx_valid && (mode_reg ==
        sdspi_pkg::MODE_IDLE)))
        else $error("completion while an exchange is still requested");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.status != sdspi_pkg::ST_OK)) |-> res_reg.done_res)
        else $error("status set without completion");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == sdspi_pkg::MODE_DATA) |->
        (byte_cnt_reg < 10'(sdspi_pkg::BLOCK_BYTES)))
        else $error("block byte count overrun");

    a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == sdspi_pkg::ACT_INIT)) |=>
        (out_valid_reg && res_reg.tx_valid && !res_reg.card_selected &&
         !res_reg.fast_clock && (mode_reg == sdspi_pkg::MODE_WAKE)))
        else $error("init start did not enter wake sequence");
`endif

endmodule
`default_nettype wire
